// ===== rtl/core/wshe_pkg.sv =====
package wshe_pkg;

	// configuration modes
	localparam logic [1:0] MODE_SINE     = 2'd0;
	localparam logic [1:0] MODE_STEEP    = 2'd1;
	localparam logic [1:0] MODE_GERSTNER = 2'd2;
	localparam logic [1:0] MODE_PASS     = 2'd3;

	// request opcodes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_POINT = 1'b1;

	// sine polynomial coefficients, Q.14
	localparam logic [14:0] SIN_A = 15'd25736;
	localparam logic [13:0] SIN_B = 14'd10512;
	localparam logic [10:0] SIN_C = 11'd1160;

	// exp2 polynomial coefficients, Q.16
	localparam logic [15:0] EXP_A1 = 16'd45585;
	localparam logic [13:0] EXP_A2 = 14'd14822;
	localparam logic [12:0] EXP_A3 = 13'd5129;

	typedef struct packed {
		logic               op;
		logic [3:0]         wave_index;
		logic [15:0]        amplitude_in;
		logic [15:0]        frequency_in;
		logic [15:0]        phase_rate_in;
		logic [15:0]        steepness_in;
		logic signed [15:0] dir_x_in;
		logic signed [15:0] dir_z_in;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_z;
		logic [31:0]        sim_time;
	} item_t;

	typedef struct packed {
		logic signed [15:0] out_x;
		logic signed [15:0] out_height;
		logic signed [15:0] out_z;
		logic               is_load_ack;
	} result_t;

	typedef struct packed {
		logic [15:0]        amp;
		logic [15:0]        freq;
		logic [15:0]        rate;
		logic [15:0]        steep;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_z;
	} wave_entry_t;

endpackage

// ===== rtl/core/wshe_sine.sv =====
module wshe_sine
	import wshe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [15:0]        angle,
	output logic               done,
	output logic signed [16:0] value
);

	logic [14:0] h;
	logic [15:0] hf;
	logic [14:0] z_fold;
	logic        neg_q;
	logic [14:0] z_q;
	logic [14:0] z2_q;
	logic [13:0] inner_q;
	logic [14:0] mid_q;
	logic [15:0] y_q;
	logic [2:0]  step_q;
	logic        done_q;
	logic [29:0] p_zz;
	logic [25:0] p_zc;
	logic [28:0] p_zi;
	logic [29:0] p_zm;

	// fold the angle into a quarter wave
	always_comb begin
		h = angle[14:0];
		hf = 16'h8000 - {1'b0, h};
		z_fold = (h > 15'h4000) ? hf[14:0] : h;
	end

	// polynomial products
	assign p_zz = z_q * z_q;
	assign p_zc = z2_q * SIN_C;
	assign p_zi = z2_q * inner_q;
	assign p_zm = z_q * mid_q;

	// control: one product per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= 3'd1;
			end else if (step_q == 3'd4) begin
				step_q <= 3'd0;
				done_q <= 1'b1;
			end else if (step_q != 3'd0) begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			z_q <= z_fold;
			neg_q <= angle[15];
		end
		case (step_q)
			3'd1: z2_q <= p_zz[28:14];
			3'd2: inner_q <= SIN_B - 14'(p_zc[25:14]);
			3'd3: mid_q <= SIN_A - p_zi[28:14];
			3'd4: y_q <= p_zm[29:14];
			default: ;
		endcase
	end

	assign done = done_q;
	assign value = neg_q ? -$signed({1'b0, y_q}) : $signed({1'b0, y_q});

endmodule

// ===== rtl/core/wshe_pow.sv =====
module wshe_pow
	import wshe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [16:0] base,
	input  logic [15:0] expo,
	output logic        done,
	output logic [16:0] value
);

	typedef enum logic [6:0] {
		P_IDLE = 7'b0000001,
		P_SQ   = 7'b0000010,
		P_NK   = 7'b0000100,
		P_E1   = 7'b0001000,
		P_E2   = 7'b0010000,
		P_E3   = 7'b0100000,
		P_FIN  = 7'b1000000
	} pow_state_t;

	pow_state_t  state_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [3:0]  e_q;
	logic [15:0] frac_q;
	logic [31:0] m_q;
	logic [15:0] k_q;
	logic [23:0] p_q;
	logic [16:0] t_q;
	logic [16:0] val_q;
	logic [3:0]  e_msb;
	logic [63:0] p_sq;
	logic [31:0] sqs;
	logic [19:0] n_neg;
	logic [35:0] p_nk;
	logic [16:0] g;
	logic [29:0] p_e1;
	logic [31:0] p_e2;
	logic [33:0] p_e3;
	logic [17:0] r_sum;
	logic [7:0]  ip;

	// msb index of the base
	always_comb begin
		e_msb = 4'd0;
		for (int i = 1; i < 16; i++) begin
			if (base[i]) e_msb = 4'(i);
		end
	end

	// log2 by squaring, then exp2 polynomial
	always_comb begin
		p_sq = m_q * m_q;
		sqs = p_sq[61:30];
		n_neg = {4'd15, 16'd0} - {e_q, frac_q};
		p_nk = n_neg * k_q;
		g = 17'h10000 - {1'b0, p_q[15:0]};
		p_e1 = g * EXP_A3;
		p_e2 = g * (17'(EXP_A2) + t_q);
		p_e3 = g * (17'(EXP_A1) + t_q);
		r_sum = 18'h10000 + {1'b0, t_q};
		ip = p_q[23:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				P_IDLE: begin
					if (start) begin
						if (expo == 16'd0 || base == 17'd0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= P_SQ;
						end
					end
				end
				P_SQ: if (cnt_q == 4'd15) state_q <= P_NK;
				P_NK: state_q <= P_E1;
				P_E1: state_q <= P_E2;
				P_E2: state_q <= P_E3;
				P_E3: state_q <= P_FIN;
				P_FIN: begin
					state_q <= P_IDLE;
					done_q <= 1'b1;
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			P_IDLE: begin
				k_q <= expo;
				e_q <= e_msb;
				m_q <= 32'(base[15:0]) << (5'd30 - {1'b0, e_msb});
				frac_q <= 16'd0;
				cnt_q <= 4'd0;
				val_q <= (expo == 16'd0) ? 17'h10000 : 17'd0;
			end
			P_SQ: begin
				cnt_q <= cnt_q + 4'd1;
				frac_q <= {frac_q[14:0], sqs[31]};
				m_q <= sqs[31] ? (sqs >> 1) : sqs;
			end
			P_NK: p_q <= p_nk[35:12];
			P_E1: t_q <= 17'(p_e1[29:16]);
			P_E2: t_q <= 17'(p_e2[31:16]);
			P_E3: t_q <= p_e3[32:16];
			P_FIN: val_q <= (ip >= 8'd32) ? 17'd0 : (r_sum[17:1] >> ip[4:0]);
			default: ;
		endcase
	end

	assign done = done_q;
	assign value = val_q;

endmodule

// ===== rtl/core/wave_sum_height_evaluator_unit.sv =====
// load request: result is registered in the cycle after acceptance
// point request, passthrough: idle leads straight to the final state, which registers
// the result once the output is free; other modes step through the waves in turn,
// steep mode through the power unit (serial log2 squaring); one request at a time
// reset clears the mode to sine and marks every table entry as a flat wave
module wave_sum_height_evaluator_unit
	import wshe_pkg::*;
#(
	parameter int NUM_WAVES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  item_t      item,
	output logic       result_valid,
	input  logic       result_stall,
	output result_t    result,
	input  logic       mode_valid,
	output logic       mode_ready,
	input  logic [1:0] mode_data
);

	localparam int IDXW = (NUM_WAVES > 1) ? $clog2(NUM_WAVES) : 1;
	localparam int LOGN = (NUM_WAVES > 1) ? $clog2(NUM_WAVES) : 0;
	localparam int ACC_XW = 56 + LOGN;
	localparam int ACC_HW = 35 + LOGN;

	typedef enum logic [19:0] {
		S_IDLE = 20'h00001,
		S_RD   = 20'h00002,
		S_MX   = 20'h00004,
		S_MZ   = 20'h00008,
		S_MF   = 20'h00010,
		S_MT   = 20'h00020,
		S_SG   = 20'h00040,
		S_SW   = 20'h00080,
		S_PG   = 20'h00100,
		S_PW   = 20'h00200,
		S_AH   = 20'h00400,
		S_CG   = 20'h00800,
		S_CW   = 20'h01000,
		S_AK   = 20'h02000,
		S_DX   = 20'h04000,
		S_AX   = 20'h08000,
		S_DZ   = 20'h10000,
		S_AZ   = 20'h20000,
		S_NX   = 20'h40000,
		S_FIN  = 20'h80000
	} state_t;

	state_t                    state_q;
	logic [1:0]                mode_q;
	logic [IDXW-1:0]           wave_q;
	wave_entry_t               mem [NUM_WAVES];
	logic [NUM_WAVES-1:0]      vld_q;
	wave_entry_t               rd_q;
	logic                      rd_vld_q;
	wave_entry_t               ent;
	logic signed [15:0]        px_q;
	logic signed [15:0]        pz_q;
	logic [31:0]               t_q;
	logic signed [31:0]        p1_q;
	logic signed [32:0]        xz_q;
	logic [33:0]               sp_q;
	logic [15:0]               ang_q;
	logic signed [16:0]        s_q;
	logic signed [16:0]        c_q;
	logic [16:0]               r_q;
	logic [19:0]               ak_q;
	logic signed [32:0]        dc_q;
	logic signed [ACC_HW-1:0]  acc_h_q;
	logic signed [ACC_XW-1:0]  acc_x_q;
	logic signed [ACC_XW-1:0]  acc_z_q;
	result_t                   result_q;
	logic                      result_valid_q;
	logic                      out_free;
	logic                      accept;
	logic                      wr_en;
	logic [IDXW-1:0]           waddr;
	wave_entry_t               wdata;
	logic                      sin_start;
	logic [15:0]               sin_angle;
	logic                      sin_done;
	logic signed [16:0]        sin_val;
	logic                      pow_start;
	logic [16:0]               pow_base;
	logic                      pow_done;
	logic [16:0]               pow_val;
	logic signed [31:0]        p_zd;
	logic signed [31:0]        p_xd;
	logic signed [49:0]        p_sf;
	logic [47:0]               p_tr;
	logic [33:0]               ph;
	logic signed [33:0]        p_as;
	logic [32:0]               p_ar;
	logic [31:0]               p_ak;
	logic signed [15:0]        dsel;
	logic signed [32:0]        p_dc;
	logic signed [53:0]        p_ad;
	logic signed [ACC_HW-1:0]  term_h;
	logic signed [ACC_XW-1:0]  hx;
	logic signed [ACC_XW-1:0]  hz;
	logic signed [ACC_HW-1:0]  hh;
	logic signed [15:0]        sat_x;
	logic signed [15:0]        sat_z;
	logic signed [15:0]        sat_h;

	// handshakes
	assign out_free = !result_valid_q || !result_stall;
	assign item_stall = (state_q != S_IDLE) || !out_free;
	assign accept = item_valid && !item_stall;
	assign mode_ready = 1'b1;
	assign result_valid = result_valid_q;
	assign result = result_q;

	// table write from a load request
	assign wr_en = accept && (item.op == OP_LOAD) && (32'(item.wave_index) < NUM_WAVES);
	assign waddr = IDXW'(item.wave_index);
	assign wdata = '{amp: item.amplitude_in, freq: item.frequency_in,
		rate: item.phase_rate_in, steep: item.steepness_in,
		dir_x: item.dir_x_in, dir_z: item.dir_z_in};

	// wave table memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem[waddr] <= wdata;
		if (state_q == S_RD) begin
			rd_q <= mem[wave_q];
			rd_vld_q <= vld_q[wave_q];
		end
	end

	// entries never loaded read as flat waves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	assign ent = rd_vld_q ? rd_q : '0;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SINE;
		end else if (mode_valid && mode_ready) begin
			mode_q <= mode_data;
		end
	end

	// shared sine unit and power unit
	assign sin_start = (state_q == S_SG) || (state_q == S_CG);
	assign sin_angle = (state_q == S_CG) ? (ang_q + 16'h4000) : ang_q;
	assign pow_start = (state_q == S_PG);
	assign pow_base = 17'(s_q + 17'sd16384);

	wshe_sine u_sine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sin_start),
		.angle  (sin_angle),
		.done   (sin_done),
		.value  (sin_val)
	);

	wshe_pow u_pow (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pow_start),
		.base   (pow_base),
		.expo   (ent.steep),
		.done   (pow_done),
		.value  (pow_val)
	);

	// per-wave products
	always_comb begin
		p_xd = px_q * ent.dir_x;
		p_zd = pz_q * ent.dir_z;
		p_sf = xz_q * $signed({1'b0, ent.freq});
		p_tr = t_q * ent.rate;
		ph = sp_q + {p_tr[27:0], 6'd0};
		p_as = $signed({1'b0, ent.amp}) * s_q;
		p_ar = ent.amp * r_q;
		p_ak = ent.amp * ent.steep;
		dsel = (state_q == S_DZ) ? ent.dir_z : ent.dir_x;
		p_dc = dsel * c_q;
		p_ad = $signed({1'b0, ak_q}) * dc_q;
		if (mode_q == MODE_STEEP) begin
			term_h = ACC_HW'($signed({1'b0, p_ar[32:1]}));
		end else begin
			term_h = ACC_HW'(p_as);
		end
	end

	// floor to Q8.8 and saturate
	always_comb begin
		hx = acc_x_q >>> 36;
		hz = acc_z_q >>> 36;
		hh = acc_h_q >>> 22;
		if (hx > ACC_XW'(32767)) sat_x = 16'sh7FFF;
		else if (hx < ACC_XW'(-32768)) sat_x = -16'sh8000;
		else sat_x = hx[15:0];
		if (hz > ACC_XW'(32767)) sat_z = 16'sh7FFF;
		else if (hz < ACC_XW'(-32768)) sat_z = -16'sh8000;
		else sat_z = hz[15:0];
		if (hh > ACC_HW'(32767)) sat_h = 16'sh7FFF;
		else if (hh < ACC_HW'(-32768)) sat_h = -16'sh8000;
		else sat_h = hh[15:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			if (!result_stall) result_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.op == OP_LOAD) begin
							result_valid_q <= 1'b1;
						end else if (mode_q == MODE_PASS) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: state_q <= S_MX;
				S_MX: state_q <= S_MZ;
				S_MZ: state_q <= S_MF;
				S_MF: state_q <= S_MT;
				S_MT: state_q <= S_SG;
				S_SG: state_q <= S_SW;
				S_SW: begin
					if (sin_done) state_q <= (mode_q == MODE_STEEP) ? S_PG : S_AH;
				end
				S_PG: state_q <= S_PW;
				S_PW: if (pow_done) state_q <= S_AH;
				S_AH: state_q <= (mode_q == MODE_GERSTNER) ? S_CG : S_NX;
				S_CG: state_q <= S_CW;
				S_CW: if (sin_done) state_q <= S_AK;
				S_AK: state_q <= S_DX;
				S_DX: state_q <= S_AX;
				S_AX: state_q <= S_DZ;
				S_DZ: state_q <= S_AZ;
				S_AZ: state_q <= S_NX;
				S_NX: state_q <= (wave_q == IDXW'(NUM_WAVES - 1)) ? S_FIN : S_RD;
				S_FIN: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					px_q <= item.pos_x;
					pz_q <= item.pos_z;
					t_q <= item.sim_time;
					wave_q <= '0;
					acc_h_q <= '0;
					acc_x_q <= ACC_XW'(item.pos_x) <<< 36;
					acc_z_q <= ACC_XW'(item.pos_z) <<< 36;
					if (item.op == OP_LOAD) result_q <= '{16'sd0, 16'sd0, 16'sd0, 1'b1};
				end
			end
			S_MX: p1_q <= p_xd;
			S_MZ: xz_q <= 33'(p1_q) + 33'(p_zd);
			S_MF: sp_q <= p_sf[33:0];
			S_MT: ang_q <= ph[33:18];
			S_SW: if (sin_done) s_q <= sin_val;
			S_PW: if (pow_done) r_q <= pow_val;
			S_AH: acc_h_q <= acc_h_q + term_h;
			S_CW: if (sin_done) c_q <= sin_val;
			S_AK: ak_q <= p_ak[31:12];
			S_DX: dc_q <= p_dc;
			S_AX: acc_x_q <= acc_x_q + ACC_XW'(p_ad);
			S_DZ: dc_q <= p_dc;
			S_AZ: acc_z_q <= acc_z_q + ACC_XW'(p_ad);
			S_NX: wave_q <= wave_q + IDXW'(1);
			S_FIN: if (out_free) result_q <= '{sat_x, sat_h, sat_z, 1'b0};
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/wshe_checker.sv =====
module wshe_checker
	import wshe_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_stall,
	input item_t      item,
	input logic       result_valid,
	input logic       result_stall,
	input result_t    result,
	input logic       mode_valid,
	input logic       mode_ready,
	input logic [1:0] mode_data
);

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// a load request is acknowledged in the next cycle
	a_load_ack: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.op == OP_LOAD |=> result_valid && result.is_load_ack)
		else $error("load request not acknowledged");

	// a load acknowledge carries zero positions
	a_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_load_ack |->
		result.out_x == 16'sd0 && result.out_height == 16'sd0 && result.out_z == 16'sd0)
		else $error("load acknowledge carries data");

	// a point request occupies the block
	a_point_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.op == OP_POINT |=> item_stall)
		else $error("request taken during point evaluation");

endmodule

bind wave_sum_height_evaluator_unit wshe_checker u_wshe_checker (.*);

// ===== test/tb_wave_sum_height_evaluator_unit.sv =====
`timescale 1ns / 1ps

module tb_wave_sum_height_evaluator_unit;
	import wshe_pkg::*;

	localparam int TABLE_SIZE = 16;
	localparam int STALL_LIMIT = 20000;

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_stall;
	item_t      item;
	logic       result_valid;
	logic       result_stall;
	result_t    result;
	logic       mode_valid;
	logic       mode_ready;
	logic [1:0] mode_data;

	bit quiet_phase;
	bit any_error;
	int idle_cycles;

	wave_sum_height_evaluator_unit #(.NUM_WAVES(TABLE_SIZE)) uut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.mode_valid(mode_valid), .mode_ready(mode_ready), .mode_data(mode_data)
	);

	// scoreboard: own copy of wave table and mode, queue of expected vertices
	class wave_scoreboard;
		logic [1:0]  mode;
		wave_entry_t waves [TABLE_SIZE];
		result_t     pending_vertices [$];
		bit          failed;

		function new();
			mode = MODE_SINE;
			foreach (waves[i]) waves[i] = '0;
			failed = 0;
		endfunction

		function automatic longint sine_q14(logic [15:0] ang);
			longint unsigned h, z2, inner, mid, y;
			bit neg;
			neg = ang[15];
			h = ang[14:0];
			if (h > 64'h4000) h = 64'h8000 - h;
			z2 = (h * h) >> 14;
			inner = SIN_B - ((z2 * SIN_C) >> 14);
			mid = SIN_A - ((z2 * inner) >> 14);
			y = (h * mid) >> 14;
			return neg ? -longint'(y) : longint'(y);
		endfunction

		function automatic longint unsigned exp2_q16(longint unsigned g);
			longint unsigned t;
			t = (g * EXP_A3) >> 16;
			t = (g * (EXP_A2 + t)) >> 16;
			t = (g * (EXP_A1 + t)) >> 16;
			return 65536 + t;
		endfunction

		// ((u)/2^15)^(k/2^12) in Q1.16
		function automatic longint unsigned power_q16(longint unsigned u, longint unsigned k);
			int e;
			longint unsigned m, frac, lg, p, ip, fp;
			if (k == 0) return 65536;
			if (u == 0) return 0;
			e = 0;
			while (e < 15 && (u >> (e + 1)) != 0) e++;
			m = u << (30 - e);
			frac = 0;
			for (int i = 0; i < 16; i++) begin
				m = (m * m) >> 30;
				frac = frac << 1;
				if (m >= (64'd1 << 31)) begin
					frac |= 1;
					m = m >> 1;
				end
			end
			lg = (longint'(e) << 16) | frac;
			p = (((64'd15 << 16) - lg) * k) >> 12;
			ip = p >> 16;
			fp = p & 64'hFFFF;
			if (ip >= 32) return 0;
			return (exp2_q16(65536 - fp) >> 1) >> ip;
		endfunction

		function automatic longint floor_shift(longint v, int k);
			return v >>> k;
		endfunction

		function automatic logic [15:0] clamp16(longint v);
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			return v[15:0];
		endfunction

		function void note_request(item_t it);
			result_t r;
			longint px, pz, acc_h, acc_x, acc_z, dx, dz, xz, s, c, ak;
			longint unsigned ph, r_pow;
			logic [15:0] ang;
			r = '0;
			if (it.op == OP_LOAD) begin
				waves[it.wave_index] = '{it.amplitude_in, it.frequency_in, it.phase_rate_in,
					it.steepness_in, it.dir_x_in, it.dir_z_in};
				r.is_load_ack = 1'b1;
				pending_vertices.push_back(r);
				return;
			end
			px = it.pos_x;
			pz = it.pos_z;
			acc_h = 0;
			acc_x = px <<< 36;
			acc_z = pz <<< 36;
			if (mode != MODE_PASS) begin
				foreach (waves[i]) begin
					dx = waves[i].dir_x;
					dz = waves[i].dir_z;
					xz = px * dx + pz * dz;
					ph = longint'(xz * longint'(waves[i].freq));
					ph += (longint'(it.sim_time) * waves[i].rate) << 6;
					ang = ph[33:18];
					s = sine_q14(ang);
					if (mode == MODE_STEEP) begin
						r_pow = power_q16(longint'(s + 16384), waves[i].steep);
						acc_h += longint'((longint'(waves[i].amp) * r_pow) >> 1);
					end else begin
						acc_h += longint'(waves[i].amp) * s;
						if (mode == MODE_GERSTNER) begin
							c = sine_q14(ang + 16'h4000);
							ak = (longint'(waves[i].amp) * longint'(waves[i].steep)) >> 12;
							acc_x += ak * (dx * c);
							acc_z += ak * (dz * c);
						end
					end
				end
			end
			r.out_x = clamp16(floor_shift(acc_x, 36));
			r.out_height = clamp16(floor_shift(acc_h, 22));
			r.out_z = clamp16(floor_shift(acc_z, 36));
			r.is_load_ack = 1'b0;
			pending_vertices.push_back(r);
		endfunction

		function void check_vertex(result_t got);
			result_t want;
			if (pending_vertices.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				failed = 1;
				return;
			end
			want = pending_vertices.pop_front();
			if (got.out_x !== want.out_x) begin
				$display("%0t: out_x expected %0d actual %0d", $time, want.out_x, got.out_x);
				failed = 1;
			end
			if (got.out_height !== want.out_height) begin
				$display("%0t: out_height expected %0d actual %0d", $time,
					want.out_height, got.out_height);
				failed = 1;
			end
			if (got.out_z !== want.out_z) begin
				$display("%0t: out_z expected %0d actual %0d", $time, want.out_z, got.out_z);
				failed = 1;
			end
			if (got.is_load_ack !== want.is_load_ack) begin
				$display("%0t: is_load_ack expected %0b actual %0b", $time,
					want.is_load_ack, got.is_load_ack);
				failed = 1;
			end
		endfunction
	endclass

	wave_scoreboard board;

	// clock
	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// result side: random stall bursts, check on accept
	initial begin
		int gap;
		result_stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) board.check_vertex(result);
			if (!quiet_phase && $urandom_range(0, 9) == 0) begin
				gap = $urandom_range(1, 18);
				result_stall <= 1;
				repeat (gap) begin
					@(posedge clk);
					// stalled, nothing accepted
				end
				result_stall <= 0;
			end
		end
	end

	// watchdog on cycles with no acceptance
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(mode_valid && mode_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_wave_sum_height_evaluator_unit: FAIL");
			$finish;
		end
	end

	// valid stays high after acceptance until the next request, an idle burst or a drain
	task automatic send_request(item_t it);
		if (!quiet_phase && $urandom_range(0, 7) == 0) begin
			item_valid <= 0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		item <= it;
		item_valid <= 1;
		do @(posedge clk); while (item_stall);
		board.note_request(it);
	endtask

	task automatic drain_results();
		item_valid <= 0;
		while (board.pending_vertices.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_mode(logic [1:0] m);
		drain_results();
		mode_data <= m;
		mode_valid <= 1;
		do @(posedge clk); while (!mode_ready);
		mode_valid <= 0;
		board.mode = m;
	endtask

	function automatic logic signed [15:0] random_dir();
		case ($urandom_range(0, 5))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	function automatic item_t random_load(bit small_amp);
		item_t it;
		it = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		it.op = OP_LOAD;
		it.dir_x_in = random_dir();
		it.dir_z_in = random_dir();
		if (small_amp) begin
			it.amplitude_in = 16'($urandom_range(0, 8191));
			it.frequency_in = 16'($urandom_range(0, 8191));
		end
		return it;
	endfunction

	function automatic item_t random_point();
		item_t it;
		it = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		it.op = OP_POINT;
		if ($urandom_range(0, 3) == 0) it.pos_x = 16'($signed($urandom_range(0, 2047)) - 1024);
		if ($urandom_range(0, 3) == 0) it.pos_z = 16'($signed($urandom_range(0, 2047)) - 1024);
		return it;
	endfunction

	initial begin
		item_t it;
		logic [1:0] modes [8];
		board = new();
		quiet_phase = 0;
		any_error = 0;
		idle_cycles = 0;
		item_valid = 0;
		item = '0;
		mode_valid = 0;
		mode_data = MODE_SINE;
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: flat table in every mode, then extremes
		for (int m = 0; m < 4; m++) begin
			write_mode(m[1:0]);
			it = '0;
			it.op = OP_POINT;
			it.pos_x = 16'sh7FFF;
			it.pos_z = -16'sh8000;
			send_request(it);
		end
		write_mode(MODE_GERSTNER);
		it = '1;
		it.op = OP_LOAD;
		it.wave_index = 4'd15;
		it.dir_x_in = 16'sd16384;
		it.dir_z_in = -16'sd16384;
		send_request(it);
		it.wave_index = 4'd0;
		it.dir_x_in = -16'sh8000;
		it.dir_z_in = 16'sh7FFF;
		send_request(it);
		it = '1;
		it.op = OP_POINT;
		send_request(it);
		it.pos_x = 16'sh7FFF;
		it.pos_z = 16'sh7FFF;
		it.sim_time = '0;
		send_request(it);
		write_mode(MODE_STEEP);
		send_request(it);
		// zero steepness, zero base cases
		it = '0;
		it.op = OP_LOAD;
		it.wave_index = 4'd3;
		it.amplitude_in = 16'hFFFF;
		it.phase_rate_in = 16'h1000;
		send_request(it);
		it.op = OP_POINT;
		it.sim_time = 32'h0000_C000;
		send_request(it);
		it.op = OP_LOAD;
		it.steepness_in = 16'hFFFF;
		send_request(it);
		it.op = OP_POINT;
		send_request(it);
		it.sim_time = 32'h0000_4000;
		send_request(it);

		// random phases across modes
		modes = '{MODE_SINE, MODE_STEEP, MODE_GERSTNER, MODE_PASS,
			MODE_GERSTNER, MODE_STEEP, MODE_SINE, MODE_GERSTNER};
		for (int ph = 0; ph < 8; ph++) begin
			write_mode(modes[ph]);
			if (ph == 7) quiet_phase = 1;
			for (int n = 0; n < 215; n++) begin
				if ($urandom_range(0, 3) == 0)
					send_request(random_load($urandom_range(0, 1)));
				else
					send_request(random_point());
			end
		end

		drain_results();
		any_error = board.failed;
		if (!any_error)
			$display("tb_wave_sum_height_evaluator_unit: PASS");
		else
			$display("tb_wave_sum_height_evaluator_unit: FAIL");
		$finish;
	end

endmodule
